// File: design/bpc_pkg.sv
package bpc_pkg;

  // Register indexes of the configuration port.
  localparam logic [2:0] CFG_TEMP_COEFFS       = 3'd0;
  localparam logic [2:0] CFG_PRESS_COEFFS_LOW  = 3'd1;
  localparam logic [2:0] CFG_PRESS_COEFFS_HIGH = 3'd2;
  localparam logic [2:0] CFG_PRESS_COEFF_NINE  = 3'd3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Fixed constants of the compensation formulas.
  localparam int T_OFFSET    = 128000;
  localparam int P_BASE      = 1048576;
  localparam int NUM_SCALE   = 3125;
  localparam int MPA_SCALE   = 1000;
  // 390625 / 100000 is exactly 125 / 32.
  localparam int FRAC_SCALE  = 125;
  localparam int FRAC_SHIFT  = 5;

  // Divider geometry: 64-bit dividend, divisor magnitude below 2^31.
  localparam int DVD_W = 64;
  localparam int DVS_W = 31;

  typedef struct packed {
    logic [23:0] raw_temperature_reg;
    logic [23:0] raw_pressure_reg;
  } bpc_sample_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [23:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [31:0]        pressure_millipascal;
    logic               pressure_valid;
  } bpc_result_t;

  // Fields that ride alongside the divider.
  typedef struct packed {
    logic [31:0] fine;
    logic [23:0] centi;
    logic        zero;
    logic        neg;
  } bpc_side_t;

  localparam int SIDE_W = $bits(bpc_side_t);

endpackage

// File: design/bpc_div.sv
module bpc_div #(
  parameter int DVD_W  = bpc_pkg::DVD_W,
  parameter int DVS_W  = bpc_pkg::DVS_W,
  parameter int SIDE_W = bpc_pkg::SIDE_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DVD_W-1:0]  in_dividend,
  input  logic [DVS_W-1:0]  in_divisor,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [DVD_W-1:0]  out_quotient,
  output logic [SIDE_W-1:0] out_side
);

  // Restoring division, one quotient bit per stage. The dividend shifts out
  // of the top of dq while quotient bits shift in at the bottom.
  logic              vld  [DVD_W+1];
  logic [DVS_W-1:0]  rem  [DVD_W+1];
  logic [DVD_W-1:0]  dq   [DVD_W+1];
  logic [DVS_W-1:0]  dvs  [DVD_W+1];
  logic [SIDE_W-1:0] side [DVD_W+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign dq[0]   = in_dividend;
  assign dvs[0]  = in_divisor;
  assign side[0] = in_side;

  for (genvar i = 0; i < DVD_W; i++) begin : g_step
    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;

    assign trial = {rem[i], dq[i][DVD_W-1]};
    assign diff  = trial - {1'b0, dvs[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vld[i];
      end
      rem[i+1]  <= diff[DVS_W] ? trial[DVS_W-1:0] : diff[DVS_W-1:0];
      dq[i+1]   <= {dq[i][DVD_W-2:0], ~diff[DVS_W]};
      dvs[i+1]  <= dvs[i];
      side[i+1] <= side[i];
    end
  end

  assign out_valid    = vld[DVD_W];
  assign out_quotient = dq[DVD_W];
  assign out_side     = side[DVD_W];

endmodule

// File: design/barometric_pressure_compensation.sv
// Barometric temperature and pressure compensation. Each start beat carries the
// raw temperature and pressure registers of the sensor; after the front stages,
// the divider and the back stages the block pulses done for one cycle with fine
// temperature, temperature in hundredths of a degree, pressure in Q24.8 pascals
// and in millipascals, and a valid flag that is low when the pressure divisor
// came out zero (both pressure fields are then zero). A new beat may be given in
// every cycle; busy stays low, and results leave on a fixed schedule, so the
// receiver must take every done beat as it comes. Most of the stages lie in
// the 64-stage pipelined divider, which yields one quotient bit per stage.
// Coefficients are loaded through cfg_we, cfg_index and cfg_data and must only
// change while no beat is in flight.
module barometric_pressure_compensation (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  bpc_pkg::bpc_sample_t                sample,
  output logic                                done,
  output bpc_pkg::bpc_result_t                result,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import bpc_pkg::*;

  // Configuration registers.
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_low;
  logic [63:0] press_coeffs_high;
  logic [15:0] press_coeff_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs       <= '0;
      press_coeffs_low  <= '0;
      press_coeffs_high <= '0;
      press_coeff_nine  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMP_COEFFS:       temp_coeffs       <= cfg_data[47:0];
        CFG_PRESS_COEFFS_LOW:  press_coeffs_low  <= cfg_data;
        CFG_PRESS_COEFFS_HIGH: press_coeffs_high <= cfg_data;
        CFG_PRESS_COEFF_NINE:  press_coeff_nine  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [15:0]        t1;
  logic signed [15:0] t2, t3;
  logic [15:0]        p1;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_coeffs[15:0];
  assign t2 = temp_coeffs[31:16];
  assign t3 = temp_coeffs[47:32];
  assign p1 = press_coeffs_low[15:0];
  assign p2 = press_coeffs_low[31:16];
  assign p3 = press_coeffs_low[47:32];
  assign p4 = press_coeffs_low[63:48];
  assign p5 = press_coeffs_high[15:0];
  assign p6 = press_coeffs_high[31:16];
  assign p7 = press_coeffs_high[47:32];
  assign p8 = press_coeffs_high[63:48];
  assign p9 = press_coeff_nine;

  // The pipeline never pushes back.
  assign busy = 1'b0;

  // Valid bits of the thirteen front stages.
  logic [12:0] fv;
  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      fv <= {fv[11:0], start && !busy};
    end
  end

  // Stage 1: ADC values, linear difference and magnitude of the square term.
  logic [19:0]        adc_t;
  logic signed [18:0] lin_diff_c;
  logic [15:0]        absd_c;
  logic signed [18:0] s1_lin_diff;
  logic [15:0]        s1_absd;
  logic [19:0]        s1_adc_p;

  assign adc_t      = sample.raw_temperature_reg[23:4];
  assign lin_diff_c = $signed({2'b0, adc_t[19:3]}) - $signed({2'b0, t1, 1'b0});
  assign absd_c     = (adc_t[19:4] >= t1) ? (adc_t[19:4] - t1) : (t1 - adc_t[19:4]);

  always_ff @(posedge clk) begin
    s1_lin_diff <= lin_diff_c;
    s1_absd     <= absd_c;
    s1_adc_p    <= sample.raw_pressure_reg[23:4];
  end

  // Stage 2: the two temperature products.
  logic signed [34:0] lin_prod_c;
  logic [31:0]        sq_prod_c;
  logic signed [31:0] s2_lin;
  logic [19:0]        s2_sq;
  logic [19:0]        s2_adc_p;

  assign lin_prod_c = s1_lin_diff * t2;
  assign sq_prod_c  = s1_absd * s1_absd;

  always_ff @(posedge clk) begin
    s2_lin   <= lin_prod_c[31:0];
    s2_sq    <= sq_prod_c[31:12];
    s2_adc_p <= s1_adc_p;
  end

  // Stage 3: square term times T3.
  logic signed [36:0] sq_t3_c;
  logic signed [31:0] s3_part1;
  logic [31:0]        s3_sq_t3;
  logic [19:0]        s3_adc_p;

  assign sq_t3_c = $signed({1'b0, s2_sq}) * t3;

  always_ff @(posedge clk) begin
    s3_part1 <= s2_lin >>> 11;
    s3_sq_t3 <= sq_t3_c[31:0];
    s3_adc_p <= s2_adc_p;
  end

  // Stage 4: fine temperature.
  logic signed [31:0] s4_fine;
  logic [19:0]        s4_adc_p;

  always_ff @(posedge clk) begin
    s4_fine  <= s3_part1 + ($signed(s3_sq_t3) >>> 14);
    s4_adc_p <= s3_adc_p;
  end

  // Stage 5: temperature in hundredths and the offset fine temperature.
  logic [31:0]        centi_sum_c;
  logic signed [33:0] a0_c;
  logic signed [33:0] a0_neg_c;
  logic [31:0]        s5_fine;
  logic [23:0]        s5_centi;
  logic signed [33:0] s5_a0;
  logic [31:0]        s5_mag;
  logic [19:0]        s5_adc_p;

  assign centi_sum_c = s4_fine + {s4_fine[29:0], 2'b0} + 32'd128;
  assign a0_c        = 34'(s4_fine) - 34'(T_OFFSET);
  assign a0_neg_c    = -a0_c;

  always_ff @(posedge clk) begin
    s5_fine  <= s4_fine;
    s5_centi <= centi_sum_c[31:8];
    s5_a0    <= a0_c;
    s5_mag   <= a0_c[33] ? a0_neg_c[31:0] : a0_c[31:0];
    s5_adc_p <= s4_adc_p;
  end

  // Stage 6: square of the offset and its products with P5 and P2.
  logic signed [49:0] a0p5_c, a0p2_c;
  logic [63:0]        s6_aa;
  logic signed [49:0] s6_a0p5, s6_a0p2;
  logic [31:0]        s6_fine;
  logic [23:0]        s6_centi;
  logic [19:0]        s6_adc_p;

  assign a0p5_c = s5_a0 * p5;
  assign a0p2_c = s5_a0 * p2;

  always_ff @(posedge clk) begin
    s6_aa    <= s5_mag * s5_mag;
    s6_a0p5  <= a0p5_c;
    s6_a0p2  <= a0p2_c;
    s6_fine  <= s5_fine;
    s6_centi <= s5_centi;
    s6_adc_p <= s5_adc_p;
  end

  // Stage 7: partial products of the square with P6 and P3.
  logic [31:0]        p6x, p3x;
  logic signed [48:0] lop6_c, lop3_c;
  logic [31:0]        hip6_c, hip3_c;
  logic signed [48:0] s7_lop6, s7_lop3;
  logic [31:0]        s7_hip6, s7_hip3;
  logic signed [49:0] s7_a0p5, s7_a0p2;
  logic [31:0]        s7_fine;
  logic [23:0]        s7_centi;
  logic [19:0]        s7_adc_p;

  assign p6x    = 32'(p6);
  assign p3x    = 32'(p3);
  assign lop6_c = $signed({1'b0, s6_aa[31:0]}) * p6;
  assign lop3_c = $signed({1'b0, s6_aa[31:0]}) * p3;
  assign hip6_c = s6_aa[63:32] * p6x;
  assign hip3_c = s6_aa[63:32] * p3x;

  always_ff @(posedge clk) begin
    s7_lop6  <= lop6_c;
    s7_lop3  <= lop3_c;
    s7_hip6  <= hip6_c;
    s7_hip3  <= hip3_c;
    s7_a0p5  <= s6_a0p5;
    s7_a0p2  <= s6_a0p2;
    s7_fine  <= s6_fine;
    s7_centi <= s6_centi;
    s7_adc_p <= s6_adc_p;
  end

  // Stage 8: sum the partial products; the P5 and P4 terms of b.
  logic [63:0]        s8_aap6, s8_aap3, s8_cb;
  logic signed [49:0] s8_a0p2;
  logic [31:0]        s8_fine;
  logic [23:0]        s8_centi;
  logic [19:0]        s8_adc_p;

  always_ff @(posedge clk) begin
    s8_aap6  <= 64'(s7_lop6) + {s7_hip6, 32'b0};
    s8_aap3  <= 64'(s7_lop3) + {s7_hip3, 32'b0};
    s8_cb    <= (64'(s7_a0p5) << 17) + (64'(p4) << 35);
    s8_a0p2  <= s7_a0p2;
    s8_fine  <= s7_fine;
    s8_centi <= s7_centi;
    s8_adc_p <= s7_adc_p;
  end

  // Stage 9: b and the first part of the divisor.
  logic [63:0] s9_b, s9_a1;
  logic [31:0] s9_fine;
  logic [23:0] s9_centi;
  logic [19:0] s9_adc_p;

  always_ff @(posedge clk) begin
    s9_b     <= s8_aap6 + s8_cb;
    s9_a1    <= 64'($signed(s8_aap3) >>> 8) + (64'(s8_a0p2) << 12);
    s9_fine  <= s8_fine;
    s9_centi <= s8_centi;
    s9_adc_p <= s8_adc_p;
  end

  // Stage 10: bias the divisor term and form the numerator before scaling.
  logic [20:0] pp_c;
  logic [63:0] s10_u, s10_nb;
  logic [31:0] s10_fine;
  logic [23:0] s10_centi;

  assign pp_c = 21'(P_BASE) - {1'b0, s9_adc_p};

  always_ff @(posedge clk) begin
    s10_u     <= s9_a1 + (64'd1 << 47);
    s10_nb    <= {12'b0, pp_c, 31'b0} - s9_b;
    s10_fine  <= s9_fine;
    s10_centi <= s9_centi;
  end

  // Stage 11: partial products with P1 and with the numerator scale.
  logic [31:0] p1x;
  logic [31:0] num_scale;
  logic [47:0] s11_ulo;
  logic [31:0] s11_uhi;
  logic [43:0] s11_nlo;
  logic [31:0] s11_nhi;
  logic [31:0] s11_fine;
  logic [23:0] s11_centi;

  assign p1x       = {16'b0, p1};
  assign num_scale = 32'(NUM_SCALE);

  always_ff @(posedge clk) begin
    s11_ulo   <= s10_u[31:0] * p1;
    s11_uhi   <= s10_u[63:32] * p1x;
    s11_nlo   <= s10_nb[31:0] * num_scale[11:0];
    s11_nhi   <= s10_nb[63:32] * num_scale;
    s11_fine  <= s10_fine;
    s11_centi <= s10_centi;
  end

  // Stage 12: divisor (upper 31 bits of the P1 product) and numerator.
  logic [63:0] a2_c;
  logic [30:0] s12_dvs;
  logic [63:0] s12_num;
  logic [31:0] s12_fine;
  logic [23:0] s12_centi;

  assign a2_c = 64'(s11_ulo) + {s11_uhi, 32'b0};

  always_ff @(posedge clk) begin
    s12_dvs   <= a2_c[63:33];
    s12_num   <= 64'(s11_nlo) + {s11_nhi, 32'b0};
    s12_fine  <= s11_fine;
    s12_centi <= s11_centi;
  end

  // Stage 13: magnitudes and signs for the unsigned divider.
  logic [DVD_W-1:0] s13_ua;
  logic [DVS_W-1:0] s13_ub;
  bpc_side_t        s13_side;

  always_ff @(posedge clk) begin
    s13_ua         <= s12_num[63] ? -s12_num : s12_num;
    s13_ub         <= s12_dvs[30] ? -s12_dvs : s12_dvs;
    s13_side.fine  <= s12_fine;
    s13_side.centi <= s12_centi;
    s13_side.zero  <= (s12_dvs == '0);
    s13_side.neg   <= s12_num[63] ^ s12_dvs[30];
  end

  logic             dv_valid;
  logic [DVD_W-1:0] dv_quot;
  bpc_side_t        dv_side;

  bpc_div #(
    .DVD_W  (DVD_W),
    .DVS_W  (DVS_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (fv[12]),
    .in_dividend  (s13_ua),
    .in_divisor   (s13_ub),
    .in_side      (s13_side),
    .out_valid    (dv_valid),
    .out_quotient (dv_quot),
    .out_side     (dv_side)
  );

  // Valid bits of the back stages: quotient sign, then seven more.
  logic [7:0] bv;
  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else begin
      bv <= {bv[6:0], dv_valid};
    end
  end

  // Back stage 0: signed quotient p.
  logic [63:0] d_p;
  bpc_side_t   d_side;

  always_ff @(posedge clk) begin
    d_p    <= dv_side.neg ? -dv_quot : dv_quot;
    d_side <= dv_side;
  end

  // Back stage 1: partial products of (p >> 13) squared and of p times P8.
  logic [63:0]        ps_c;
  logic [31:0]        p8x;
  logic signed [48:0] plo8_c;
  logic [63:0]        b1_lolo;
  logic [31:0]        b1_lohi;
  logic signed [48:0] b1_plo8;
  logic [31:0]        b1_phi8;
  logic [63:0]        b1_p;
  bpc_side_t          b1_side;

  assign ps_c   = 64'($signed(d_p) >>> 13);
  assign p8x    = 32'(p8);
  assign plo8_c = $signed({1'b0, d_p[31:0]}) * p8;

  always_ff @(posedge clk) begin
    b1_lolo <= ps_c[31:0] * ps_c[31:0];
    b1_lohi <= ps_c[31:0] * ps_c[63:32];
    b1_plo8 <= plo8_c;
    b1_phi8 <= d_p[63:32] * p8x;
    b1_p    <= d_p;
    b1_side <= d_side;
  end

  // Back stage 2: the square and p times P8.
  logic [63:0] b2_sq, b2_pp8, b2_p;
  bpc_side_t   b2_side;

  always_ff @(posedge clk) begin
    b2_sq   <= b1_lolo + {b1_lohi[30:0], 33'b0};
    b2_pp8  <= 64'(b1_plo8) + {b1_phi8, 32'b0};
    b2_p    <= b1_p;
    b2_side <= b1_side;
  end

  // Back stage 3: square times P9 partials; p plus its P8 correction.
  logic [31:0]        p9x;
  logic signed [48:0] sqlo9_c;
  logic signed [48:0] b3_sqlo9;
  logic [31:0]        b3_sqhi9;
  logic [63:0]        b3_pb;
  bpc_side_t          b3_side;

  assign p9x     = 32'(p9);
  assign sqlo9_c = $signed({1'b0, b2_sq[31:0]}) * p9;

  always_ff @(posedge clk) begin
    b3_sqlo9 <= sqlo9_c;
    b3_sqhi9 <= b2_sq[63:32] * p9x;
    b3_pb    <= b2_p + 64'($signed(b2_pp8) >>> 19);
    b3_side  <= b2_side;
  end

  // Back stage 4: the P9 product.
  logic [63:0] b4_prod9, b4_pb;
  bpc_side_t   b4_side;

  always_ff @(posedge clk) begin
    b4_prod9 <= 64'(b3_sqlo9) + {b3_sqhi9, 32'b0};
    b4_pb    <= b3_pb;
    b4_side  <= b3_side;
  end

  // Back stage 5: full sum before the final shift.
  logic [63:0] b5_s;
  bpc_side_t   b5_side;

  always_ff @(posedge clk) begin
    b5_s    <= b4_pb + 64'($signed(b4_prod9) >>> 25);
    b5_side <= b4_side;
  end

  // Back stage 6: Q24.8 pressure; only the low 40 bits matter from here on.
  logic [63:0] pf_c;
  logic [39:0] b6_pf;
  bpc_side_t   b6_side;

  assign pf_c = 64'($signed(b5_s) >>> 8) + (64'(p7) << 4);

  always_ff @(posedge clk) begin
    b6_pf   <= pf_c[39:0];
    b6_side <= b5_side;
  end

  // Back stage 7: millipascals and the output register.
  logic [31:0] mpa_scale;
  logic [14:0] frac_c;
  logic [31:0] mpa_c;

  assign mpa_scale = 32'(MPA_SCALE);
  assign frac_c    = b6_pf[7:0] * 7'(FRAC_SCALE);
  assign mpa_c     = b6_pf[39:8] * mpa_scale + 32'(frac_c >> FRAC_SHIFT);

  always_ff @(posedge clk) begin
    result.fine_temperature     <= b6_side.fine;
    result.temperature_centi    <= b6_side.centi;
    result.pressure_q24_8       <= b6_side.zero ? 32'd0 : b6_pf[31:0];
    result.pressure_millipascal <= b6_side.zero ? 32'd0 : mpa_c;
    result.pressure_valid       <= ~b6_side.zero;
  end

  assign done = bv[7];

endmodule
